>>> sv/pstcc_pkg.sv
// Package with the item types, classes and helpers shared by the pedal converter modules.
`timescale 1ns / 1ps
package pstcc_pkg;
    localparam int WindowDepth    = 5;
    localparam int AdcFullScale   = 4095;
    localparam int MinCalSpan     = 64;
    localparam int EmitIntervalMs = 20;
    localparam logic [21:0] RecipFive  = 22'd838861;
    localparam logic [14:0] RecipScale = 15'd16514;
    localparam logic [7:0]  CcStatus   = 8'hB0;

    localparam logic [2:0] REG_HEEL   = 3'd0;
    localparam logic [2:0] REG_TOE    = 3'd1;
    localparam logic [2:0] REG_ENABLE = 3'd2;
    localparam logic [2:0] REG_CHAN   = 3'd3;
    localparam logic [2:0] REG_CTRL   = 3'd4;
    localparam logic [2:0] REG_INVERT = 3'd5;
    localparam logic [2:0] REG_MIN    = 3'd6;
    localparam logic [2:0] REG_MAX    = 3'd7;

    typedef enum logic [1:0] {CLS_OFF, CLS_ABSENT, CLS_PROC} t_cls;

    typedef struct packed {
        logic [11:0] adc_sample;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic        send_message;
        logic [7:0]  status_byte;
        logic [6:0]  cc_number;
        logic [6:0]  cc_value;
        logic        pedal_present;
        logic [6:0]  current_level;
    } t_out_item;

    typedef struct packed {
        t_cls        cls;
        logic [11:0] adc;
        logic [31:0] time_ms;
    } t_cls_item;

    typedef struct packed {
        logic [11:0] heel;
        logic [11:0] toe;
        logic        enable;
        logic [4:0]  chan;
        logic [6:0]  ctrl;
        logic        invert;
        logic [6:0]  omin;
        logic [6:0]  omax;
    } t_cfg;

    typedef struct packed {
        logic wr;
        logic cal;
    } t_cfg_evt;

    function automatic logic cal_ok(input t_cfg c);
        logic [11:0] span;
        span = c.toe - c.heel;
        return (c.toe > c.heel) && (span >= 12'(MinCalSpan));
    endfunction
endpackage

>>> sv/pstcc_front.sv
// Front stage: accepts input items and classifies them as disabled, absent or processed.
`timescale 1ns / 1ps
module pstcc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pstcc_pkg::t_in_item i_in_item,
    input  pstcc_pkg::t_cfg     i_cfg,
    output logic                o_valid,
    input  logic                i_ready,
    output pstcc_pkg::t_cls_item o_item
);
    logic                 r_valid;
    pstcc_pkg::t_cls_item r_item;
    pstcc_pkg::t_cls_item n_item;
    logic                 take;

    assign o_in_stall = r_valid && !i_ready;
    assign take       = i_in_valid && !o_in_stall;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_comb begin
        n_item.adc     = i_in_item.adc_sample;
        n_item.time_ms = i_in_item.time_ms;
        if (!pstcc_pkg::cal_ok(i_cfg) || !i_cfg.enable) begin
            n_item.cls = pstcc_pkg::CLS_OFF;
        end else if (i_in_item.adc_sample == 12'd0 ||
                     i_in_item.adc_sample == 12'(pstcc_pkg::AdcFullScale)) begin
            n_item.cls = pstcc_pkg::CLS_ABSENT;
        end else begin
            n_item.cls = pstcc_pkg::CLS_PROC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_item <= n_item;
        end
    end
endmodule

>>> sv/pstcc_queue.sv
// Two-entry queue between the classifying front and the processing back.
`timescale 1ns / 1ps
module pstcc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pstcc_pkg::t_cls_item i_item,
    output logic                 o_ready,
    input  logic                 i_pop,
    output logic                 o_valid,
    output pstcc_pkg::t_cls_item o_item
);
    pstcc_pkg::t_cls_item r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= !r_wp;
            end
            if (pop_ok) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
        if (push_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

>>> sv/pstcc_back.sv
// Back stage: median window, smoothing, calibrated scaling, mapping and message pacing.
`timescale 1ns / 1ps
module pstcc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_pop,
    input  pstcc_pkg::t_cls_item  i_item,
    input  pstcc_pkg::t_cfg       i_cfg,
    input  pstcc_pkg::t_cfg_evt   i_evt,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pstcc_pkg::t_out_item  o_out_item
);
    typedef enum logic [2:0] {
        S_IDLE, S_MED, S_MUL, S_UPD, S_CLAMP, S_DIV, S_NORM, S_SCL
    } t_state;

    t_state      r_state;
    logic [11:0] r_win [pstcc_pkg::WindowDepth];
    logic [2:0]  r_cursor;
    logic [2:0]  r_fill;
    logic [19:0] r_sm;
    logic        r_sv;
    logic        r_clk_st;
    logic [31:0] r_last_t;
    logic        r_lvv;
    logic [6:0]  r_lv;
    logic [19:0] r_diff;
    logic        r_up;
    logic [41:0] r_prod;
    logic [18:0] r_num;
    logic [11:0] r_rem;
    logic [4:0]  r_cnt;
    logic [13:0] r_p2;
    logic [31:0] r_time;
    logic        r_out_valid;
    pstcc_pkg::t_out_item r_out;

    logic [11:0] med;
    logic [2:0]  rank;
    logic [19:0] target;
    logic [12:0] filt;
    logic [11:0] clamped;
    logic [11:0] span;
    logic [12:0] rem_sh;
    logic        qbit;
    logic [6:0]  norm;
    logic [6:0]  ospan;
    logic [28:0] scl;
    logic [6:0]  mapped;
    logic [31:0] dt;
    logic        emit;
    logic [7:0]  status;
    logic        out_free;
    logic        out_set;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == S_IDLE) && i_valid && out_free && !i_evt.wr;
    assign out_set     = (o_pop && (i_item.cls != pstcc_pkg::CLS_PROC)) ||
                         (!i_evt.wr && (r_state == S_SCL));
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign span        = i_cfg.toe - i_cfg.heel;
    assign status      = pstcc_pkg::CcStatus | {4'd0, 4'(i_cfg.chan - 5'd1)};

    always_comb begin
        med = 12'd0;
        for (int i = 0; i < pstcc_pkg::WindowDepth; i++) begin
            rank = 3'd0;
            for (int j = 0; j < pstcc_pkg::WindowDepth; j++) begin
                if (3'(j) < r_fill && (r_win[j] < r_win[i] ||
                                       (r_win[j] == r_win[i] && j < i))) begin
                    rank = rank + 3'd1;
                end
            end
            if (3'(i) < r_fill && rank == (r_fill >> 1)) begin
                med = r_win[i];
            end
        end
        target = {med, 8'd0};
    end

    always_comb begin
        filt = 13'((r_sm + 20'd128) >> 8);
        if (filt < {1'b0, i_cfg.heel}) begin
            clamped = i_cfg.heel;
        end else if (filt > {1'b0, i_cfg.toe}) begin
            clamped = i_cfg.toe;
        end else begin
            clamped = filt[11:0];
        end
        rem_sh = {r_rem, r_num[18]};
        qbit   = (rem_sh >= {1'b0, span});
        norm   = (r_num > 19'd127) ? 7'd127 : r_num[6:0];
        if (i_cfg.invert) begin
            norm = 7'd127 - norm;
        end
        ospan  = (i_cfg.omax > i_cfg.omin) ? (i_cfg.omax - i_cfg.omin) : 7'd0;
        scl    = 29'(r_p2) * 29'(pstcc_pkg::RecipScale);
        mapped = i_cfg.omin + scl[27:21];
        dt     = r_time - r_last_t;
        emit   = r_clk_st && (dt >= 32'(pstcc_pkg::EmitIntervalMs)) &&
                 !(r_lvv && mapped == r_lv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= 3'd0;
            r_fill      <= 3'd0;
            r_sm        <= 20'd0;
            r_sv        <= 1'b0;
            r_clk_st    <= 1'b0;
            r_last_t    <= 32'd0;
            r_lvv       <= 1'b0;
            r_lv        <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_set) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_evt.wr) begin
                r_lvv <= 1'b0;
                if (i_evt.cal) begin
                    r_fill   <= 3'd0;
                    r_cursor <= 3'd0;
                    r_sv     <= 1'b0;
                end
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (o_pop) begin
                            r_out <= '0;
                            case (i_item.cls)
                                pstcc_pkg::CLS_PROC: begin
                                    r_win[r_cursor] <= i_item.adc;
                                    r_cursor <= (r_cursor == 3'(pstcc_pkg::WindowDepth - 1)) ?
                                                3'd0 : r_cursor + 3'd1;
                                    if (r_fill < 3'(pstcc_pkg::WindowDepth)) begin
                                        r_fill <= r_fill + 3'd1;
                                    end
                                    r_time  <= i_item.time_ms;
                                    r_state <= S_MED;
                                end
                                pstcc_pkg::CLS_ABSENT: begin
                                    r_lvv <= 1'b0;
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    S_MED: begin
                        if (!r_sv) begin
                            r_sm    <= target;
                            r_sv    <= 1'b1;
                            r_state <= S_CLAMP;
                        end else begin
                            r_up    <= (target >= r_sm);
                            r_diff  <= (target >= r_sm) ? target - r_sm : r_sm - target;
                            r_state <= S_MUL;
                        end
                    end
                    S_MUL: begin
                        r_prod  <= 42'(r_diff) * 42'(pstcc_pkg::RecipFive);
                        r_state <= S_UPD;
                    end
                    S_UPD: begin
                        r_sm    <= r_up ? r_sm + r_prod[41:22] : r_sm - r_prod[41:22];
                        r_state <= S_CLAMP;
                    end
                    S_CLAMP: begin
                        r_num   <= 19'(clamped - i_cfg.heel) * 19'd127 + 19'(span >> 1);
                        r_rem   <= 12'd0;
                        r_cnt   <= 5'd19;
                        r_state <= S_DIV;
                    end
                    S_DIV: begin
                        r_rem <= qbit ? 12'(rem_sh - {1'b0, span}) : rem_sh[11:0];
                        r_num <= {r_num[17:0], qbit};
                        r_cnt <= r_cnt - 5'd1;
                        if (r_cnt == 5'd1) begin
                            r_state <= S_NORM;
                        end
                    end
                    S_NORM: begin
                        r_p2    <= 14'(norm) * 14'(ospan) + 14'd63;
                        r_state <= S_SCL;
                    end
                    S_SCL: begin
                        r_out.pedal_present <= 1'b1;
                        r_out.current_level <= mapped;
                        if (!r_clk_st) begin
                            r_clk_st <= 1'b1;
                            r_last_t <= r_time;
                        end else if (emit) begin
                            r_lv     <= mapped;
                            r_lvv    <= 1'b1;
                            r_last_t <= r_time;
                            r_out.send_message <= 1'b1;
                            r_out.status_byte  <= status;
                            r_out.cc_number    <= i_cfg.ctrl;
                            r_out.cc_value     <= mapped;
                        end
                        r_state <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end
endmodule

>>> sv/pedal_sample_to_control_change_top.sv
// Top level of the pedal sample to control change converter.
`timescale 1ns / 1ps
// Usage: each input item carries a 12-bit pedal sample and a millisecond
// timestamp; each item yields exactly one result item on the output channel.
// Both channels use valid and stall, an item moving when valid is high and
// stall is low. Configuration registers are written through a plain write port
// (enable, index, data); the user writes them only while the block is idle, which
// the block does not enforce. A sample flows through a front register and a
// two-entry queue into the back part, which handles one item at a time. A
// disabled or absent item passes the front register and the queue, and its
// result is loaded into the output register as the back part pops it. A
// processed item passes them too, then a median state, the smoothing states, a
// clamp state, a restoring divider that scales to 0..127, and the mapping
// states. The first item after the window is emptied skips the smoothing
// states. The back part takes no new item until it is through with the last
// one; the divider is the longest of its steps. Reset restores the register
// defaults and empties the window, the smoothing and the message pacing. When
// the receiver stalls, the result is held in the output register, the back part
// waits, and the queue and front register fill before the input stall rises.
module pedal_sample_to_control_change_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pstcc_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pstcc_pkg::t_out_item  o_out_item,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [11:0]           i_cfg_data
);
    pstcc_pkg::t_cfg      r_cfg;
    pstcc_pkg::t_cfg      n_cfg;
    pstcc_pkg::t_cfg_evt  evt;
    pstcc_pkg::t_cls_item f_item;
    pstcc_pkg::t_cls_item q_item;
    logic                 f_valid;
    logic                 q_ready;
    logic                 q_valid;
    logic                 q_pop;

    always_comb begin
        n_cfg = r_cfg;
        unique case (i_cfg_idx)
            pstcc_pkg::REG_HEEL:   n_cfg.heel   = i_cfg_data;
            pstcc_pkg::REG_TOE:    n_cfg.toe    = i_cfg_data;
            pstcc_pkg::REG_ENABLE: n_cfg.enable = i_cfg_data[0];
            pstcc_pkg::REG_CHAN:   n_cfg.chan   = i_cfg_data[4:0];
            pstcc_pkg::REG_CTRL:   n_cfg.ctrl   = i_cfg_data[6:0];
            pstcc_pkg::REG_INVERT: n_cfg.invert = i_cfg_data[0];
            pstcc_pkg::REG_MIN:    n_cfg.omin   = i_cfg_data[6:0];
            default:               n_cfg.omax   = i_cfg_data[6:0];
        endcase
        evt.wr  = i_cfg_we;
        evt.cal = (i_cfg_idx == pstcc_pkg::REG_HEEL) || (i_cfg_idx == pstcc_pkg::REG_TOE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heel   <= 12'd0;
            r_cfg.toe    <= 12'd4095;
            r_cfg.enable <= 1'b1;
            r_cfg.chan   <= 5'd1;
            r_cfg.ctrl   <= 7'd11;
            r_cfg.invert <= 1'b0;
            r_cfg.omin   <= 7'd0;
            r_cfg.omax   <= 7'd127;
        end else if (i_cfg_we) begin
            r_cfg <= n_cfg;
        end
    end

    pstcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_cfg      (r_cfg),
        .o_valid    (f_valid),
        .i_ready    (q_ready),
        .o_item     (f_item)
    );

    pstcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    pstcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_item      (q_item),
        .i_cfg       (r_cfg),
        .i_evt       (evt),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.send_message |-> o_out_item.status_byte[7:4] == 4'hB)
        else $error("message status byte is not a control change");
    a_send_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.send_message |-> o_out_item.pedal_present)
        else $error("message sent while pedal not present");
    a_level_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.pedal_present |-> o_out_item.current_level == 7'd0)
        else $error("level shown while pedal absent");
endmodule

>>> tb/sv/pstcc_checker.sv
// Checker that watches the pedal converter channels, predicts each result item and compares.
`timescale 1ns / 1ps
module pstcc_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  pstcc_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  pstcc_pkg::t_out_item i_out_item,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [11:0]          i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_sent,
    output int                   o_results
);
    logic [11:0] heel, toe, omin, omax;
    logic [4:0]  chan;
    logic [6:0]  ctrl;
    logic        enable, invert;
    logic [11:0] window [pstcc_pkg::WindowDepth];
    int unsigned cursor, fill;
    logic [31:0] smooth_q8, last_time;
    logic        smooth_ok, clock_started, last_ok, view_present;
    logic [6:0]  last_sent, view_level;
    pstcc_pkg::t_out_item expected_q[$];

    function automatic logic calib_good();
        return toe > heel && (toe - heel) >= pstcc_pkg::MinCalSpan &&
               toe <= pstcc_pkg::AdcFullScale;
    endfunction

    function automatic logic [31:0] window_median();
        logic [11:0] s [pstcc_pkg::WindowDepth];
        logic [11:0] v;
        int j;
        for (int i = 0; i < fill; i++) s[i] = window[i];
        for (int i = 1; i < fill; i++) begin
            v = s[i];
            j = i;
            while (j > 0 && s[j-1] > v) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = v;
        end
        return s[fill/2];
    endfunction

    function automatic logic [6:0] scale_level(logic [31:0] f);
        logic [31:0] c, span, norm, ospan;
        span = toe - heel;
        c = f;
        if (c < heel) c = heel;
        if (c > toe) c = toe;
        if (span == 0) span = 1;
        norm = ((c - heel) * 127 + span / 2) / span;
        if (norm > 127) norm = 127;
        if (invert) norm = 127 - norm;
        ospan = omax > omin ? omax - omin : 0;
        return 7'(omin + (norm * ospan + 63) / 127);
    endfunction

    task automatic predict_control_change(pstcc_pkg::t_in_item it);
        pstcc_pkg::t_out_item r;
        logic [31:0] target, mapped;
        logic send;
        send = 0;
        r = '0;
        if (!calib_good() || !enable) begin
            view_present = 0;
            view_level = 0;
        end else if (it.adc_sample == 0 || it.adc_sample == pstcc_pkg::AdcFullScale) begin
            view_present = 0;
            view_level = 0;
            last_ok = 0;
        end else begin
            view_present = 1;
            window[cursor] = it.adc_sample;
            cursor = (cursor + 1) % pstcc_pkg::WindowDepth;
            if (fill < pstcc_pkg::WindowDepth) fill++;
            target = window_median() << 8;
            if (!smooth_ok) begin
                smooth_q8 = target;
                smooth_ok = 1;
            end else if (target >= smooth_q8) begin
                smooth_q8 += (target - smooth_q8) / 5;
            end else begin
                smooth_q8 -= (smooth_q8 - target) / 5;
            end
            mapped = scale_level((smooth_q8 + 128) >> 8);
            view_level = mapped[6:0];
            if (!clock_started) begin
                clock_started = 1;
                last_time = it.time_ms;
            end else if (32'(it.time_ms - last_time) >= pstcc_pkg::EmitIntervalMs
                         && !(last_ok && mapped[6:0] == last_sent)) begin
                send = 1;
                last_sent = mapped[6:0];
                last_ok = 1;
                last_time = it.time_ms;
            end
        end
        if (send) begin
            r.send_message = 1;
            r.status_byte = pstcc_pkg::CcStatus | {4'h0, 4'(chan - 1)};
            r.cc_number = ctrl;
            r.cc_value = last_sent;
        end
        r.pedal_present = view_present;
        r.current_level = view_level;
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_errors++;
    endtask

    task automatic compare_result(pstcc_pkg::t_out_item g);
        pstcc_pkg::t_out_item e;
        if (expected_q.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
            return;
        end
        e = expected_q.pop_front();
        if (g.send_message != e.send_message)
            report_mismatch("send_message", g.send_message, e.send_message);
        if (g.status_byte != e.status_byte)
            report_mismatch("status_byte", g.status_byte, e.status_byte);
        if (g.cc_number != e.cc_number) report_mismatch("cc_number", g.cc_number, e.cc_number);
        if (g.cc_value != e.cc_value) report_mismatch("cc_value", g.cc_value, e.cc_value);
        if (g.pedal_present != e.pedal_present)
            report_mismatch("pedal_present", g.pedal_present, e.pedal_present);
        if (g.current_level != e.current_level)
            report_mismatch("current_level", g.current_level, e.current_level);
        if (g.send_message) o_sent++;
        o_results++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            heel = 0; toe = 4095; enable = 1; chan = 1; ctrl = 11;
            invert = 0; omin = 0; omax = 127;
            cursor = 0; fill = 0; smooth_q8 = 0; smooth_ok = 0;
            clock_started = 0; last_time = 0; last_ok = 0; last_sent = 0;
            view_level = 0;
            view_present = calib_good();
            expected_q.delete();
            o_errors = 0;
            o_sent = 0;
            o_results = 0;
        end else begin
            if (i_out_valid && !i_out_stall) compare_result(i_out_item);
            if (i_in_valid && !i_in_stall) predict_control_change(i_in_item);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pstcc_pkg::REG_HEEL:   heel = i_cfg_data;
                    pstcc_pkg::REG_TOE:    toe = i_cfg_data;
                    pstcc_pkg::REG_ENABLE: enable = i_cfg_data[0];
                    pstcc_pkg::REG_CHAN:   chan = i_cfg_data[4:0];
                    pstcc_pkg::REG_CTRL:   ctrl = i_cfg_data[6:0];
                    pstcc_pkg::REG_INVERT: invert = i_cfg_data[0];
                    pstcc_pkg::REG_MIN:    omin = {5'd0, i_cfg_data[6:0]};
                    default:               omax = {5'd0, i_cfg_data[6:0]};
                endcase
                last_ok = 0;
                view_level = 0;
                if (i_cfg_idx == pstcc_pkg::REG_HEEL || i_cfg_idx == pstcc_pkg::REG_TOE) begin
                    fill = 0;
                    cursor = 0;
                    smooth_ok = 0;
                    view_present = calib_good();
                end else begin
                    view_present = calib_good() && enable;
                end
            end
        end
        o_pending = expected_q.size();
    end
endmodule

>>> tb/sv/tb_top.sv
// Testbench top that drives the pedal converter and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    localparam int IdleLimit = 20000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0, in_stall, out_valid, out_stall = 0;
    pstcc_pkg::t_in_item  in_item = '0;
    pstcc_pkg::t_out_item out_item;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = '0;
    logic [11:0] cfg_data = '0;
    int          errors, pending, sent, results;
    int          idle_pct = 34;
    bit          hold_off = 0;
    int          quiet = 0;
    int          accepted = 0;
    logic [31:0] now_ms = 0;

    pedal_sample_to_control_change_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    pstcc_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_sent(sent), .o_results(results)
    );

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk) begin
        if (hold_off) out_stall <= 1;
        else out_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= IdleLimit) begin
            $display("timeout with %0d items outstanding", pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_sample(logic [11:0] adc, int unsigned step_ms);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        now_ms = now_ms + step_ms;
        in_valid <= 1;
        in_item <= '{adc_sample: adc, time_ms: now_ms};
        do @(posedge clk); while (in_stall);
        accepted++;
    endtask

    function automatic logic [11:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 12'd0;
        if (r < 8) return 12'd4095;
        if (r < 20) return 12'($urandom);
        return 12'($urandom_range(3900, 150));
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_sample(pick_sample(), $urandom_range(99) < 70 ?
                        $urandom_range(40, 15) : $urandom_range(1000, 0));
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, absent pedal, first sample, interval limits.
        send_sample(12'd2000, 5);
        send_sample(12'd0, 30);
        send_sample(12'd4095, 30);
        send_sample(12'd1, 30);
        send_sample(12'd4094, 19);
        send_sample(12'd4094, 20);
        send_sample(12'd4094, 20);
        send_sample(12'd2048, 25);
        send_sample(12'hAAA, 25);
        send_sample(12'h555, 25);
        now_ms = 32'hFFFF_FFF0;
        send_sample(12'd3000, 0);
        send_sample(12'd1000, 30);
        drain();

        write_reg(pstcc_pkg::REG_HEEL, 12'd500);
        write_reg(pstcc_pkg::REG_TOE, 12'd3500);
        write_reg(pstcc_pkg::REG_INVERT, 12'd1);
        write_reg(pstcc_pkg::REG_CHAN, 12'd16);
        write_reg(pstcc_pkg::REG_CTRL, 12'd127);
        write_reg(pstcc_pkg::REG_MIN, 12'd20);
        write_reg(pstcc_pkg::REG_MAX, 12'd100);
        send_sample(12'd100, 30);
        send_sample(12'd3900, 30);
        send_sample(12'd2000, 30);
        send_sample(12'd2500, 30);
        drain();

        write_reg(pstcc_pkg::REG_MAX, 12'd5);
        write_reg(pstcc_pkg::REG_CHAN, 12'd0);
        write_reg(pstcc_pkg::REG_ENABLE, 12'd0);
        send_sample(12'd1500, 30);
        drain();
        write_reg(pstcc_pkg::REG_ENABLE, 12'd1);
        write_reg(pstcc_pkg::REG_TOE, 12'd530);
        send_sample(12'd1500, 30);
        drain();
        write_reg(pstcc_pkg::REG_TOE, 12'd564);
        send_sample(12'd520, 30);
        send_sample(12'd560, 30);
        drain();

        // Random phases over several register settings.
        write_reg(pstcc_pkg::REG_HEEL, 12'd0);
        write_reg(pstcc_pkg::REG_TOE, 12'd4095);
        write_reg(pstcc_pkg::REG_INVERT, 12'd0);
        write_reg(pstcc_pkg::REG_MIN, 12'd0);
        write_reg(pstcc_pkg::REG_MAX, 12'd127);
        write_reg(pstcc_pkg::REG_CHAN, 12'd1);
        random_phase(100);
        drain();

        idle_pct = 0;
        random_phase(60);
        drain();
        idle_pct = 34;

        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            random_phase(20);
        join
        drain();

        for (int p = 0; p < 5; p++) begin
            write_reg(pstcc_pkg::REG_HEEL, 12'($urandom_range(2000)));
            write_reg(pstcc_pkg::REG_TOE, 12'($urandom_range(4095, 1900)));
            write_reg(pstcc_pkg::REG_INVERT, 12'($urandom_range(1)));
            write_reg(pstcc_pkg::REG_CHAN, 12'($urandom_range(31)));
            write_reg(pstcc_pkg::REG_CTRL, 12'($urandom_range(127)));
            write_reg(pstcc_pkg::REG_MIN, 12'($urandom_range(127)));
            write_reg(pstcc_pkg::REG_MAX, 12'($urandom_range(127)));
            write_reg(pstcc_pkg::REG_ENABLE, 12'($urandom_range(99) < 85));
            random_phase(55);
            drain();
        end

        $display("Run covered %0d samples, %0d results, %0d control changes,", accepted,
                 results, sent);
        $display("across calibration, mapping, enable and pacing settings.");
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
